FILE: rtl/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// types and constants shared by the sorted key table and its checker
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CAPACITY      = 64;
    localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int KEY_W         = 32;
    localparam int PAYLOAD_W     = 64;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_HEAD,
        ST_FIND,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        t_op                    op;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]   payload;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_res;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } t_entry;

endpackage

FILE: rtl/sorted_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// operation: an insert walks down from the top, moving each entry whose key
//   is not below the new key up one slot, then writes the new entry; a remove
//   scans up from entry 0 and shifts the entries above the match down; an
//   empty-table insert, full-table insert and empty-table remove end at idle
// throughput: one item at a time, the next accepted as the result shows, one
//   table entry per cycle; reset: synchronous, clears the entry count and
//   control state; the result strobe cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  skt_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output skt_pkg::t_res o_res
);

    skt_pkg::t_entry r_mem [skt_pkg::CAPACITY];
    skt_pkg::t_entry r_rd_data;

    skt_pkg::t_state                r_state, n_state;
    logic [skt_pkg::ADDR_W-1:0]     r_ptr, n_ptr;
    logic [skt_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_done, n_done;
    skt_pkg::t_status               r_status, n_status;
    skt_pkg::t_req                  r_req;

    logic                           mem_we;
    logic [skt_pkg::ADDR_W-1:0]     mem_waddr;
    skt_pkg::t_entry                mem_wdata;
    logic                           mem_re;
    logic [skt_pkg::ADDR_W-1:0]     mem_raddr;

    logic                           accept;
    logic [skt_pkg::ADDR_W-1:0]     last_idx;
    skt_pkg::t_entry                new_entry;

    assign accept    = start && (r_state == skt_pkg::ST_IDLE);
    assign last_idx  = skt_pkg::ADDR_W'(r_count - skt_pkg::CNT_W'(1));
    assign new_entry = '{key: r_req.key, payload: r_req.payload};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (n_done) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::ST_IDLE;
            r_ptr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = skt_pkg::STAT_DONE;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = new_entry;
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (r_state)
            skt_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_req.op == skt_pkg::OP_INSERT) begin
                        if (r_count == skt_pkg::CNT_W'(skt_pkg::CAPACITY)) begin
                            n_done   = 1'b1;
                            n_status = skt_pkg::STAT_FULL;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = '{key: i_req.key, payload: i_req.payload};
                            n_count   = r_count + skt_pkg::CNT_W'(1);
                            n_done    = 1'b1;
                            n_status  = skt_pkg::STAT_DONE;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = last_idx;
                            n_ptr     = last_idx;
                            n_state   = skt_pkg::ST_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = skt_pkg::STAT_NOT_FOUND;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_ptr     = '0;
                            n_state   = skt_pkg::ST_FIND;
                        end
                    end
                end
            end

            // walk down from the top, moving entries up until the slot is found
            skt_pkg::ST_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr + skt_pkg::ADDR_W'(1);
                if (r_rd_data.key >= r_req.key) begin
                    mem_wdata = r_rd_data;
                    if (r_ptr == '0) begin
                        n_state = skt_pkg::ST_INS_HEAD;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_ptr - skt_pkg::ADDR_W'(1);
                        n_ptr     = r_ptr - skt_pkg::ADDR_W'(1);
                    end
                end else begin
                    mem_wdata = new_entry;
                    n_count   = r_count + skt_pkg::CNT_W'(1);
                    n_done    = 1'b1;
                    n_status  = skt_pkg::STAT_DONE;
                    n_state   = skt_pkg::ST_IDLE;
                end
            end

            skt_pkg::ST_INS_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_entry;
                n_count   = r_count + skt_pkg::CNT_W'(1);
                n_done    = 1'b1;
                n_status  = skt_pkg::STAT_DONE;
                n_state   = skt_pkg::ST_IDLE;
            end

            skt_pkg::ST_FIND: begin
                if (r_rd_data.key == r_req.key) begin
                    if (r_ptr == last_idx) begin
                        n_count  = r_count - skt_pkg::CNT_W'(1);
                        n_done   = 1'b1;
                        n_status = skt_pkg::STAT_DONE;
                        n_state  = skt_pkg::ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_ptr + skt_pkg::ADDR_W'(1);
                        n_ptr     = r_ptr + skt_pkg::ADDR_W'(1);
                        n_state   = skt_pkg::ST_SHIFT;
                    end
                end else if (r_ptr == last_idx) begin
                    n_done   = 1'b1;
                    n_status = skt_pkg::STAT_NOT_FOUND;
                    n_state  = skt_pkg::ST_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + skt_pkg::ADDR_W'(1);
                    n_ptr     = r_ptr + skt_pkg::ADDR_W'(1);
                end
            end

            // close the gap left by the removed entry
            skt_pkg::ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr - skt_pkg::ADDR_W'(1);
                mem_wdata = r_rd_data;
                if (r_ptr == last_idx) begin
                    n_count  = r_count - skt_pkg::CNT_W'(1);
                    n_done   = 1'b1;
                    n_status = skt_pkg::STAT_DONE;
                    n_state  = skt_pkg::ST_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + skt_pkg::ADDR_W'(1);
                    n_ptr     = r_ptr + skt_pkg::ADDR_W'(1);
                end
            end

            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != skt_pkg::ST_IDLE);
    assign o_done            = r_done;
    assign o_res.status      = r_status;
    assign o_res.entry_count = skt_pkg::ENTRY_COUNT_W'(r_count);

endmodule

FILE: rtl/skt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker
// port level checks on the sorted key table, bound into the sorted_key_table module
// ----------------------------------------------------------------------------
module skt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          busy,
    input logic          o_done,
    input skt_pkg::t_res o_res
);

    // a long operation always ends with a result transfer
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // count moves only with a result
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> $stable(o_res.entry_count))
        else $error("entry count changed without a result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == skt_pkg::STAT_FULL) |->
        (o_res.entry_count == skt_pkg::ENTRY_COUNT_W'(skt_pkg::CAPACITY)))
        else $error("full reported below capacity");

    a_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == skt_pkg::STAT_DONE) |->
        (o_res.entry_count != $past(o_res.entry_count)))
        else $error("completed operation left the count unchanged");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the sorted key table against a shadow copy of the table kept here:
// directed inserts and removes at the key and payload extremes, duplicate
// keys, a full table and an empty table, then random traffic that fills and
// drains the table; every result is compared with the shadow outcome
// ----------------------------------------------------------------------------
module tb;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    skt_pkg::t_req i_req;
    logic          busy;
    logic          o_done;
    skt_pkg::t_res o_res;

    sorted_key_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    logic signed [skt_pkg::KEY_W-1:0] shadow_keys [skt_pkg::CAPACITY];
    logic [skt_pkg::PAYLOAD_W-1:0]    shadow_payloads [skt_pkg::CAPACITY];
    int                               shadow_count;
    skt_pkg::t_res                    outcome_q [$];
    int                               err_cnt;
    bit                               idle_on;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("sorted_key_table: mismatch");
        $finish;
    end

    // shadow table update for one accepted transfer
    task automatic shadow_apply(input skt_pkg::t_req r);
        logic signed [skt_pkg::KEY_W-1:0] k;
        int                               pos;
        int                               j;
        skt_pkg::t_res                    want;
        k = r.key;
        pos = 0;
        if (r.op == skt_pkg::OP_INSERT) begin
            if (shadow_count >= skt_pkg::CAPACITY) begin
                want.status = skt_pkg::STAT_FULL;
            end else begin
                while (pos < shadow_count && shadow_keys[pos] < k) pos++;
                for (j = shadow_count; j > pos; j--) begin
                    shadow_keys[j]     = shadow_keys[j-1];
                    shadow_payloads[j] = shadow_payloads[j-1];
                end
                shadow_keys[pos]     = k;
                shadow_payloads[pos] = r.payload;
                shadow_count++;
                want.status = skt_pkg::STAT_DONE;
            end
        end else begin
            while (pos < shadow_count && shadow_keys[pos] != k) pos++;
            if (pos >= shadow_count) begin
                want.status = skt_pkg::STAT_NOT_FOUND;
            end else begin
                for (j = pos; j + 1 < shadow_count; j++) begin
                    shadow_keys[j]     = shadow_keys[j+1];
                    shadow_payloads[j] = shadow_payloads[j+1];
                end
                shadow_count--;
                want.status = skt_pkg::STAT_DONE;
            end
        end
        want.entry_count = skt_pkg::ENTRY_COUNT_W'(shadow_count);
        outcome_q.push_back(want);
    endtask

    task automatic pause_sender();
        int           n;
        logic [127:0] junk;
        n = $urandom_range(1, 15);
        junk = {$urandom, $urandom, $urandom, $urandom};
        start <= 1'b0;
        i_req <= junk[$bits(skt_pkg::t_req)-1:0];
        repeat (n) @(posedge i_clk);
    endtask

    // start stays high on return unless a pause drops it, so back-to-back transfers need no toggle
    task automatic send_item(input skt_pkg::t_op op,
                             input logic signed [skt_pkg::KEY_W-1:0] key,
                             input logic [skt_pkg::PAYLOAD_W-1:0] payload);
        skt_pkg::t_req r;
        r.op      = op;
        r.key     = key;
        r.payload = payload;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        shadow_apply(r);
        if (idle_on && $urandom_range(0, 2) == 0) pause_sender();
    endtask

    function automatic logic [skt_pkg::PAYLOAD_W-1:0] rand_payload();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [skt_pkg::KEY_W-1:0] rand_key(input bit for_remove);
        int sel;
        sel = $urandom_range(0, 9);
        if (for_remove) begin
            if (shadow_count > 0 && sel < 7)
                return shadow_keys[$urandom_range(0, shadow_count - 1)];
            if (sel == 9) return $urandom;
            return $signed($urandom_range(0, 16)) - 8;
        end
        if (sel < 4) return $signed($urandom_range(0, 16)) - 8;
        if (sel < 6 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (sel == 6) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_table();
        send_item(skt_pkg::OP_REMOVE, 32'sd0, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sh8000_0000, '1);
    endtask

    task automatic test_key_extremes();
        send_item(skt_pkg::OP_INSERT, 32'sh7FFF_FFFF, '1);
        send_item(skt_pkg::OP_INSERT, 32'sh8000_0000, '0);
        send_item(skt_pkg::OP_INSERT, 32'sd0, 64'hA5A5_A5A5_5A5A_5A5A);
        send_item(skt_pkg::OP_INSERT, -32'sd1, 64'h5A5A_5A5A_A5A5_A5A5);
        send_item(skt_pkg::OP_INSERT, 32'sd1, 64'h0123_4567_89AB_CDEF);
        send_item(skt_pkg::OP_REMOVE, 32'sh7FFF_FFFF, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sh8000_0000, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sd7, '1);
    endtask

    task automatic test_duplicates();
        send_item(skt_pkg::OP_INSERT, 32'sd3, 64'd1);
        send_item(skt_pkg::OP_INSERT, 32'sd3, 64'd2);
        send_item(skt_pkg::OP_INSERT, 32'sd3, 64'd3);
        send_item(skt_pkg::OP_INSERT, 32'sd2, 64'd4);
        send_item(skt_pkg::OP_INSERT, 32'sd4, 64'd5);
        send_item(skt_pkg::OP_REMOVE, 32'sd3, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sd3, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sd3, '0);
        send_item(skt_pkg::OP_REMOVE, 32'sd3, '0);
    endtask

    task automatic test_fill_and_drain();
        while (shadow_count < skt_pkg::CAPACITY)
            send_item(skt_pkg::OP_INSERT, rand_key(1'b0), rand_payload());
        repeat (3) send_item(skt_pkg::OP_INSERT, rand_key(1'b0), rand_payload());
        send_item(skt_pkg::OP_REMOVE, 32'sh1234_5679, rand_payload());
        send_item(skt_pkg::OP_REMOVE, shadow_keys[skt_pkg::CAPACITY-1], rand_payload());
        send_item(skt_pkg::OP_INSERT, 32'sh7FFF_FFFF, rand_payload());
        send_item(skt_pkg::OP_INSERT, 32'sh8000_0000, rand_payload());
        send_item(skt_pkg::OP_REMOVE, shadow_keys[0], rand_payload());
        while (shadow_count > 0)
            send_item(skt_pkg::OP_REMOVE,
                      shadow_keys[$urandom_range(0, shadow_count - 1)],
                      rand_payload());
        send_item(skt_pkg::OP_REMOVE, rand_key(1'b1), rand_payload());
    endtask

    task automatic test_random_mix(input int n_items, input int insert_pct);
        bit is_ins;
        repeat (n_items) begin
            is_ins = ($urandom_range(0, 99) < insert_pct);
            if (is_ins)
                send_item(skt_pkg::OP_INSERT, rand_key(1'b0), rand_payload());
            else
                send_item(skt_pkg::OP_REMOVE, rand_key(1'b1), rand_payload());
        end
    endtask

    always @(posedge i_clk) begin : check_results
        skt_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d count %0d",
                         $time, o_res.status, o_res.entry_count);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_res.status);
                    err_cnt++;
                end
                if (o_res.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, o_res.entry_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        err_cnt      = 0;
        shadow_count = 0;
        idle_on      = 1'b1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_key_extremes();
        test_duplicates();
        test_fill_and_drain();
        test_random_mix(300, 50);
        test_random_mix(300, 75);
        test_random_mix(300, 25);
        idle_on = 1'b0;
        test_random_mix(200, 55);

        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (skt_pkg::CAPACITY + 8) @(posedge i_clk);
        if (err_cnt == 0 && outcome_q.size() == 0) begin
            $display("sorted_key_table: match");
        end else begin
            $display("sorted_key_table: mismatch");
        end
        $finish;
    end

endmodule
